@@ src/assert_macros.svh @@
// Assertion macros shared by the stepper drive RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check under a synchronous active-low reset.
`define BSW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define BSW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bsw_pkg.sv @@
// Package for the button stepper wave drive: widths, codes, reset values, types.
// No dependencies.
`timescale 1ns / 1ps
package bsw_pkg;

  localparam int BSW_PERIOD_BITS = 24;

  localparam int BTN_W     = 4;
  localparam int PHASE_W   = 4;
  localparam int DIR_W     = 2;
  localparam int PERIOD_W  = 24;
  localparam int SETTLE_W  = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Pressed codes (active low buttons)
  localparam logic [BTN_W-1:0] CODE_CW   = 4'hE;
  localparam logic [BTN_W-1:0] CODE_CCW  = 4'hD;
  localparam logic [BTN_W-1:0] CODE_FAST = 4'hB;
  localparam logic [BTN_W-1:0] CODE_SLOW = 4'h7;
  localparam logic [BTN_W-1:0] ALL_UP    = 4'hF;

  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'h1;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'h8;

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd3;

  localparam logic [SETTLE_W-1:0] RST_SETTLE = 20'd80000;
  localparam logic [PERIOD_W-1:0] RST_STEP   = 24'd499999;
  localparam logic [PERIOD_W-1:0] RST_MIN    = 24'd499999;
  localparam logic [PERIOD_W-1:0] RST_MAX    = 24'd16777215;
  localparam logic [31:0]         RST_PERIOD = 32'd3999999;

  typedef struct packed {
    logic             act;
    logic [BTN_W-1:0] code;
  } bsw_evt_t;

  typedef struct packed {
    logic [PHASE_W-1:0]  coil_phase;
    logic                step_taken;
    logic [DIR_W-1:0]    direction;
    logic [PERIOD_W-1:0] period_now;
  } bsw_res_t;

endpackage

@@ src/bsw_if.sv @@
// Valid/ready channel interfaces for button input and drive result.
// Depends on bsw_pkg.
`timescale 1ns / 1ps
interface bsw_in_if import bsw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] buttons;

  modport source (output valid, output buttons, input ready);
  modport sink   (input valid, input buttons, output ready);
endinterface

interface bsw_out_if import bsw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PHASE_W-1:0]  coil_phase;
  logic                step_taken;
  logic [DIR_W-1:0]    direction;
  logic [PERIOD_W-1:0] period_now;

  modport source (output valid, output coil_phase, output step_taken,
                  output direction, output period_now, input ready);
  modport sink   (input valid, input coil_phase, input step_taken,
                  input direction, input period_now, output ready);
endinterface

@@ src/button_stepper_wave_drive.sv @@
// A tick in the input register moves through the logic into the result register when
// that register is empty or being read. Throughput: one tick per cycle unless out_ch
// stalls, set by the single input register -> logic -> result register pass.
// Reset (rst_n, synchronous, active low): drive/debounce state, config registers and
// both valid flags return to their reset values; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module button_stepper_wave_drive import bsw_pkg::*; #(
  parameter int PERIOD_BITS = BSW_PERIOD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bsw_in_if.sink               in_ch,
  bsw_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic [SETTLE_W-1:0] settle_r;
  logic [PERIOD_W-1:0] step_r, min_r, max_r;

  logic             in_vld_r;
  logic [BTN_W-1:0] in_btn_r;
  logic             out_vld_r;
  bsw_res_t         out_res_r;
  logic             adv;
  bsw_evt_t         evt;
  bsw_res_t         res;

  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= RST_SETTLE;
      step_r   <= RST_STEP;
      min_r    <= RST_MIN;
      max_r    <= RST_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETTLE: settle_r <= cfg_wdata[SETTLE_W-1:0];
        REG_STEP:   step_r   <= cfg_wdata[PERIOD_W-1:0];
        REG_MIN:    min_r    <= cfg_wdata[PERIOD_W-1:0];
        REG_MAX:    max_r    <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_btn_r <= in_ch.buttons;
    end
  end

  bsw_debounce u_deb (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .buttons      (in_btn_r),
    .settle_ticks (settle_r),
    .evt          (evt)
  );

  bsw_drive #(.PERIOD_BITS(PERIOD_BITS)) u_drv (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .evt        (evt),
    .speed_step (step_r),
    .min_period (min_r),
    .max_period (max_r),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.coil_phase = out_res_r.coil_phase;
  assign out_ch.step_taken = out_res_r.step_taken;
  assign out_ch.direction  = out_res_r.direction;
  assign out_ch.period_now = out_res_r.period_now;

  `BSW_ASSERT(a_adv_fills_out, clk, rst_n, adv |=> out_vld_r, "processed tick did not reach result register")
  `BSW_ASSERT(a_stall_keeps_in, clk, rst_n, in_vld_r && !adv |=> in_vld_r && $stable(in_btn_r), "stalled tick lost from input register")
  `BSW_ASSERT(a_no_overwrite, clk, rst_n, out_vld_r && !out_ch.ready |-> !adv, "pending result overwritten")

endmodule

@@ src/bsw_debounce.sv @@
// Two-sample button debouncer: qualifies a press, then a release, and
// reports the held code on release. Depends on bsw_pkg.
`timescale 1ns / 1ps
module bsw_debounce import bsw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [BTN_W-1:0]    buttons,
  input  logic [SETTLE_W-1:0] settle_ticks,
  output bsw_evt_t            evt
);

  logic [SETTLE_W-1:0] win_r, win_nxt;
  logic [BTN_W-1:0]    first_r, first_nxt;
  logic [BTN_W-1:0]    held_r, held_nxt;
  logic                await_r, await_nxt;
  logic                same;

  assign same = (first_r == buttons);

  always_comb begin
    win_nxt   = win_r;
    first_nxt = first_r;
    held_nxt  = held_r;
    await_nxt = await_r;
    evt.act   = 1'b0;
    evt.code  = held_r;
    if (win_r == '0) begin
      first_nxt = buttons;
      win_nxt   = SETTLE_W'(1);
    end else if (win_r >= settle_ticks) begin
      // second sample; a failed check just restarts the window
      win_nxt = '0;
      if (!await_r) begin
        if (same && buttons != ALL_UP) begin
          held_nxt  = buttons;
          await_nxt = 1'b1;
        end
      end else if (same && buttons == ALL_UP) begin
        evt.act   = 1'b1;
        held_nxt  = ALL_UP;
        await_nxt = 1'b0;
      end
    end else begin
      win_nxt = win_r + SETTLE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      first_r <= ALL_UP;
      held_r  <= ALL_UP;
      await_r <= 1'b0;
    end else if (en) begin
      win_r   <= win_nxt;
      first_r <= first_nxt;
      held_r  <= held_nxt;
      await_r <= await_nxt;
    end
  end

endmodule

@@ src/bsw_drive.sv @@
// Step countdown, one-hot coil rotation and saturating period control.
// Depends on bsw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsw_drive import bsw_pkg::*; #(
  parameter int PERIOD_BITS = BSW_PERIOD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  bsw_evt_t            evt,
  input  logic [PERIOD_W-1:0] speed_step,
  input  logic [PERIOD_W-1:0] min_period,
  input  logic [PERIOD_W-1:0] max_period,
  output bsw_res_t            res
);

  // wide enough for either operand plus a carry
  localparam int CW = ((PERIOD_BITS > PERIOD_W) ? PERIOD_BITS : PERIOD_W) + 1;
  localparam logic [CW-1:0] MASK = {{(CW-PERIOD_BITS){1'b0}}, {PERIOD_BITS{1'b1}}};
  localparam logic [PERIOD_BITS-1:0] RST_RELOAD = RST_PERIOD[PERIOD_BITS-1:0];

  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [DIR_W-1:0]       rot_r, rot_nxt;
  logic [PERIOD_BITS-1:0] reload_r, reload_nxt;
  logic [PERIOD_BITS-1:0] cnt_r, cnt_nxt;
  logic                   expired;
  logic [CW-1:0]          reload_x, step_x, min_x, max_x, v;
  logic                   chg;

  assign expired  = (cnt_r == '0);
  assign reload_x = CW'(reload_r);
  assign step_x   = CW'(speed_step);
  assign min_x    = CW'(min_period);
  assign max_x    = CW'(max_period);

  always_comb begin
    phase_nxt = phase_r;
    rot_nxt   = rot_r;
    cnt_nxt   = expired ? reload_r : cnt_r - PERIOD_BITS'(1);
    if (expired) begin
      if (rot_r == DIR_CW) begin
        phase_nxt = (phase_r == PHASE_FIRST) ? PHASE_LAST : (phase_r >> 1);
      end else if (rot_r == DIR_CCW) begin
        phase_nxt = (phase_r == PHASE_LAST) ? PHASE_FIRST : (phase_r << 1);
      end
    end

    chg = 1'b0;
    v   = reload_x;
    if (evt.act) begin
      case (evt.code)
        CODE_CW:  rot_nxt = DIR_CW;
        CODE_CCW: rot_nxt = DIR_CCW;
        CODE_FAST: begin
          chg = 1'b1;
          v   = (reload_x > step_x) ? reload_x - step_x : '0;
          if (v < min_x) v = min_x;
        end
        CODE_SLOW: begin
          chg = 1'b1;
          v   = reload_x + step_x;
          if (v > max_x) v = max_x;
        end
        default: ;
      endcase
    end
    if (v > MASK) v = MASK;
    if (v == '0) v = CW'(1);
    reload_nxt = chg ? v[PERIOD_BITS-1:0] : reload_r;
    // a period change restarts the countdown over the expiry reload
    if (chg) cnt_nxt = step_x[PERIOD_BITS-1:0];

    res.coil_phase = phase_nxt;
    res.step_taken = expired;
    res.direction  = rot_nxt;
    res.period_now = PERIOD_W'(reload_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PHASE_FIRST;
      rot_r    <= DIR_STOP;
      reload_r <= RST_RELOAD;
      cnt_r    <= RST_RELOAD;
    end else if (en) begin
      phase_r  <= phase_nxt;
      rot_r    <= rot_nxt;
      reload_r <= reload_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `BSW_ASSERT(a_phase_onehot, clk, rst_n, $onehot(phase_r), "coil phase not one-hot")
  `BSW_ASSERT(a_reload_nonzero, clk, rst_n, reload_r != '0, "step period reached zero")
  `BSW_ASSERT(a_hold_when_idle, clk, rst_n, !en |=> $stable(phase_r) && $stable(cnt_r) && $stable(reload_r), "drive state moved without a tick")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the button stepper wave drive.
// Uses bsw_pkg and the bsw_in_if / bsw_out_if channel interfaces.
`timescale 1ns / 1ps
module testbench;
  import bsw_pkg::*;

  localparam int           CYCLE_LIMIT = 400000;
  localparam longint unsigned PERIOD_MASK = (64'd1 << BSW_PERIOD_BITS) - 1;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic [BTN_W-1:0]     btn;
    logic                 typed;
    bsw_res_t             want;
  } script_row_t;

  localparam bsw_res_t NONE = '0;
  localparam int N_ROWS = 30;
  // Directed opening: period floor, stopped expiry, failed check, other code,
  // then every operation. Windows are two ticks long with settle_ticks at 1.
  localparam script_row_t SCRIPT [N_ROWS] = '{
    '{1'b1, REG_SETTLE, 24'd1,        ALL_UP,    1'b0, NONE},
    '{1'b1, REG_STEP,   24'd16777215, ALL_UP,    1'b0, NONE},
    '{1'b1, REG_MIN,    24'd1,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0, CODE_FAST, 1'b1,
      '{PHASE_FIRST, 1'b0, DIR_STOP, 24'd3999999}},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_FAST, 1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0, ALL_UP, 1'b1, '{PHASE_FIRST, 1'b0, DIR_STOP, 24'd1}},
    '{1'b1, REG_STEP,   24'd1,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_FAST, 1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_FAST, 1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_CW,   1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0, CODE_CCW, 1'b1, '{PHASE_FIRST, 1'b1, DIR_STOP, 24'd1}},
    '{1'b0, REG_SETTLE, 24'd0,        4'h0,      1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        4'h0,      1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_CW,   1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_CW,   1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_CCW,  1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_CCW,  1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_SLOW, 1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        CODE_SLOW, 1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE},
    '{1'b0, REG_SETTLE, 24'd0,        ALL_UP,    1'b0, NONE}
  };

  // Random phases: settle, step, min, max and tick count per phase
  localparam int N_PHASES = 5;
  localparam logic [CFG_DAT_W-1:0] PH_SETTLE [N_PHASES] =
    '{24'd3, 24'd1048575, 24'd2, 24'd0, 24'd1};
  localparam logic [CFG_DAT_W-1:0] PH_STEP [N_PHASES] =
    '{24'd16777215, 24'd1, 24'd1, 24'd5, 24'd3};
  localparam logic [CFG_DAT_W-1:0] PH_MIN [N_PHASES] =
    '{24'd1, 24'd1, 24'd2, 24'd0, 24'd1};
  localparam logic [CFG_DAT_W-1:0] PH_MAX [N_PHASES] =
    '{24'd16777215, 24'd1, 24'd6, 24'd16777215, 24'd40};
  localparam int PH_TICKS [N_PHASES] = '{120, 40, 400, 320, 400};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  bsw_in_if  in_ch ();
  bsw_out_if out_ch ();

  button_stepper_wave_drive dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predicted drive state and register copies
  logic [PHASE_W-1:0]  coil;
  logic [DIR_W-1:0]    rot;
  logic [PERIOD_W-1:0] reload;
  logic [PERIOD_W-1:0] countdown;
  logic                awaiting_release;
  logic [SETTLE_W-1:0] window;
  logic [BTN_W-1:0]    first_btn;
  logic [BTN_W-1:0]    held;
  logic [SETTLE_W-1:0] settle_r;
  logic [PERIOD_W-1:0] step_r;
  logic [PERIOD_W-1:0] min_r;
  logic [PERIOD_W-1:0] max_r;

  bsw_res_t drive_results_due [$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       ticks_sent = 0;
  int       results_seen = 0;
  bit       in_calm = 1'b0;
  bit       out_calm = 1'b0;

  // One tick of the drive: countdown first, then the debounce window.
  function automatic bsw_res_t drive_tick(input logic [BTN_W-1:0] btn);
    bsw_res_t        r;
    logic            took;
    logic            match;
    longint unsigned v;
    took = 1'b0;
    if (countdown == '0) begin
      took = 1'b1;
      countdown = reload;
      if (rot == DIR_CW) begin
        coil = (coil == PHASE_FIRST) ? PHASE_LAST : (coil >> 1);
      end else if (rot == DIR_CCW) begin
        coil = (coil == PHASE_LAST) ? PHASE_FIRST : (coil << 1);
      end
    end else begin
      countdown = countdown - 1'b1;
    end
    if (window == '0) begin
      first_btn = btn;
      window = SETTLE_W'(1);
    end else if (window >= settle_r) begin
      match = (first_btn == btn);
      window = '0;
      if (!awaiting_release) begin
        if (match && btn != ALL_UP) begin
          held = btn;
          awaiting_release = 1'b1;
        end
      end else if (match && btn == ALL_UP) begin
        if (held == CODE_CW) begin
          rot = DIR_CW;
        end else if (held == CODE_CCW) begin
          rot = DIR_CCW;
        end else if (held == CODE_FAST || held == CODE_SLOW) begin
          if (held == CODE_FAST) begin
            v = (reload > step_r) ? 64'(reload - step_r) : 64'd0;
            if (v < 64'(min_r)) v = 64'(min_r);
          end else begin
            v = 64'(reload) + 64'(step_r);
            if (v > 64'(max_r)) v = 64'(max_r);
          end
          if (v > PERIOD_MASK) v = PERIOD_MASK;
          if (v == 64'd0) v = 64'd1;
          reload = v[PERIOD_W-1:0];
          countdown = step_r;
        end
        held = ALL_UP;
        awaiting_release = 1'b0;
      end
    end else begin
      window = window + 1'b1;
    end
    r.coil_phase = coil;
    r.step_taken = took;
    r.direction  = rot;
    r.period_now = reload;
    return r;
  endfunction

  // Register writes only once the drive has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (drive_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SETTLE: settle_r = val[SETTLE_W-1:0];
      REG_STEP:   step_r   = val[PERIOD_W-1:0];
      REG_MIN:    min_r    = val[PERIOD_W-1:0];
      REG_MAX:    max_r    = val[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_btn(input logic [BTN_W-1:0] b, input logic use_typed,
                          input bsw_res_t typed_res);
    int       gap;
    bsw_res_t predicted;
    if (ticks_sent % 50 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.buttons <= b;
    do @(posedge clk); while (!in_ch.ready);
    predicted = drive_tick(b);
    drive_results_due.push_back(use_typed ? typed_res : predicted);
    ticks_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, compare each transfer with the oldest prediction.
  initial begin
    int       stall;
    bsw_res_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (results_seen % 50 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      results_seen++;
      if (drive_results_due.size() == 0) begin
        $error("drive result with nothing expected");
        mismatches++;
      end else begin
        want = drive_results_due.pop_front();
        if (out_ch.coil_phase !== want.coil_phase) begin
          $error("coil_phase: expected %0h, got %0h", want.coil_phase, out_ch.coil_phase);
          mismatches++;
        end
        if (out_ch.step_taken !== want.step_taken) begin
          $error("step_taken: expected %0d, got %0d", want.step_taken, out_ch.step_taken);
          mismatches++;
        end
        if (out_ch.direction !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, out_ch.direction);
          mismatches++;
        end
        if (out_ch.period_now !== want.period_now) begin
          $error("period_now: expected %0d, got %0d", want.period_now, out_ch.period_now);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int               p;
    int               goal;
    int               hold;
    int               rel;
    int               s_eff;
    int               kind;
    logic [BTN_W-1:0] code;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SETTLE;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.buttons <= ALL_UP;
    coil             = PHASE_FIRST;
    rot              = DIR_STOP;
    reload           = RST_PERIOD[PERIOD_W-1:0];
    countdown        = RST_PERIOD[PERIOD_W-1:0];
    awaiting_release = 1'b0;
    window           = '0;
    first_btn        = ALL_UP;
    held             = ALL_UP;
    settle_r         = RST_SETTLE;
    step_r           = RST_STEP;
    min_r            = RST_MIN;
    max_r            = RST_MAX;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      if (SCRIPT[i].is_cfg) begin
        write_reg(SCRIPT[i].idx, SCRIPT[i].data);
      end else begin
        send_btn(SCRIPT[i].btn, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    for (p = 0; p < N_PHASES; p++) begin
      write_reg(REG_SETTLE, PH_SETTLE[p]);
      write_reg(REG_STEP, PH_STEP[p]);
      write_reg(REG_MIN, PH_MIN[p]);
      write_reg(REG_MAX, PH_MAX[p]);
      s_eff = (settle_r == 0) ? 1 : int'(settle_r);
      goal  = ticks_sent + PH_TICKS[p];
      while (ticks_sent < goal) begin
        kind = $urandom_range(0, 19);
        case ($urandom_range(0, 4))
          0:       code = CODE_CW;
          1:       code = CODE_CCW;
          2:       code = CODE_FAST;
          3:       code = CODE_SLOW;
          default: code = BTN_W'($urandom_range(0, 15));
        endcase
        if (kind < 3) begin
          // noise
          repeat ($urandom_range(1, 4)) send_btn(BTN_W'($urandom_range(0, 15)), 1'b0, NONE);
        end else begin
          // a hold of 2*settle+1 ticks always spans one full window
          if (s_eff > 16) begin
            hold = $urandom_range(1, 6);
            rel  = $urandom_range(1, 6);
          end else if (kind < 6) begin
            hold = $urandom_range(1, s_eff + 1);
            rel  = $urandom_range(1, s_eff + 1);
          end else begin
            hold = 2 * s_eff + 1 + $urandom_range(0, 2);
            rel  = 2 * s_eff + 1 + $urandom_range(0, 2);
          end
          repeat (hold) send_btn(code, 1'b0, NONE);
          repeat (rel) send_btn(ALL_UP, 1'b0, NONE);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (drive_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
